@@ rtl/mbs_pkg.sv @@
// Package: shared types and constants for the median background subtractor.
package mbs_pkg;

  localparam int unsigned WindowDefault    = 10;
  localparam int unsigned MaxPixelsDefault = 524288;
  localparam logic [15:0] PeriodReset      = 16'd100;
  localparam logic [7:0]  ThresholdReset   = 8'd50;

  localparam logic [0:0] RegPeriod    = 1'b0;
  localparam logic [0:0] RegThreshold = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SORT,
    ST_LOOK,
    ST_OUT
  } mbs_state_e;

  typedef struct packed {
    logic load;
    logic read;
    logic sort_start;
    logic sort_step;
    logic bg_read;
    logic finish;
  } mbs_cmd_t;

  typedef struct packed {
    logic sampling;
    logic emit;
    logic sort_done;
    logic out_busy;
  } mbs_sts_t;

endpackage

@@ rtl/mbs_ctrl.sv @@
// Controller: sequences read, median sort, background lookup and result hand-off.
module mbs_ctrl
  import mbs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mbs_sts_t sts_i,
  output mbs_cmd_t cmd_o
);

  mbs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = sts_i.sampling ? ST_SORT : ST_LOOK;
        cmd_o.sort_start = sts_i.sampling;
      end
      ST_SORT: begin
        cmd_o.sort_step = 1'b1;
        if (sts_i.sort_done) begin
          state_d = ST_OUT;
        end
      end
      ST_LOOK: begin
        cmd_o.bg_read = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/mbs_datapath.sv @@
// Datapath: sample ring memory, background memory, median sorter and output register.
module mbs_datapath
  import mbs_pkg::*;
#(
  parameter int unsigned Window    = WindowDefault,
  parameter int unsigned MaxPixels = MaxPixelsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] gray_pixel_i,
  input  logic       end_of_frame_i,
  input  logic [15:0] sample_period_i,
  input  logic [7:0] fg_threshold_i,
  input  mbs_cmd_t   cmd_i,
  output mbs_sts_t   sts_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       foreground_o,
  output logic [7:0] difference_o,
  output logic [7:0] background_level_o,
  output logic       last_of_frame_o
);

  localparam int unsigned PosW  = (MaxPixels > 1) ? $clog2(MaxPixels) : 1;
  localparam int unsigned SlotW = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned CntW  = $clog2(Window + 1);
  localparam int unsigned StepW = $clog2(Window + 2);

  logic [Window*8-1:0] ring_mem [MaxPixels];
  logic [7:0]          bg_mem   [MaxPixels];

  logic [PosW-1:0]  pos_q;
  logic [15:0]      phase_q;
  logic [CntW-1:0]  held_q;
  logic [SlotW-1:0] slot_q;
  logic [7:0]       pix_q;
  logic             eof_q, samp_q;
  logic [CntW-1:0]  cnt_q;
  logic [Window*8-1:0] rdw_q;
  logic [7:0]       vals_q [Window];
  logic [StepW-1:0] step_q;
  logic [7:0]       bg_q;
  logic [7:0]       bg_rd_q;
  logic             bg_sel_q;

  logic       sampling;
  logic [7:0] bg_use;
  logic [8:0] diff_full;
  logic [7:0] diff;
  logic [Window*8-1:0] merged;

  assign sampling = (phase_q + 16'd1) == sample_period_i;
  assign bg_use   = bg_sel_q ? bg_rd_q : bg_q;
  assign diff_full = {1'b0, pix_q} - {1'b0, bg_use};
  assign diff      = diff_full[8] ? 8'd0 : diff_full[7:0];

  assign sts_o.sampling  = samp_q;
  assign sts_o.sort_done = step_q == StepW'(Window + 1);
  assign sts_o.emit      = cnt_q == CntW'(Window);
  assign sts_o.out_busy  = out_valid_o && out_stall_i;

  // ring word read and write, background memory read and write
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rdw_q <= ring_mem[pos_q];
    end
    if (cmd_i.sort_step && !sts_o.sort_done && step_q == '0) begin
      ring_mem[pos_q] <= merged;
    end
    if (cmd_i.bg_read) begin
      bg_rd_q <= bg_mem[pos_q];
    end
    if (cmd_i.sort_step && sts_o.sort_done) begin
      bg_mem[pos_q] <= vals_q[cnt_q >> 1];
    end
  end

  // the read word must include the new sample; merge in the ring write path
  always_comb begin
    merged = rdw_q;
    merged[slot_q*8 +: 8] = pix_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q <= gray_pixel_i;
      eof_q <= end_of_frame_i;
    end
    if (cmd_i.sort_step && !sts_o.sort_done) begin
      if (step_q == '0) begin
        for (int i = 0; i < Window; i++) begin
          vals_q[i] <= (CntW'(i) < cnt_q) ? merged[i*8 +: 8] : 8'hFF;
        end
      end else begin
        // odd-even transposition pass
        for (int i = 0; i + 1 < Window; i++) begin
          if ((i % 2) == (step_q[0] ? 1 : 0)) begin
            if (vals_q[i] > vals_q[i+1]) begin
              vals_q[i]   <= vals_q[i+1];
              vals_q[i+1] <= vals_q[i];
            end
          end
        end
      end
    end
    if (cmd_i.sort_step && sts_o.sort_done) begin
      bg_q <= vals_q[cnt_q >> 1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      phase_q     <= '0;
      held_q      <= '0;
      slot_q      <= '0;
      samp_q      <= 1'b0;
      cnt_q       <= '0;
      step_q      <= '0;
      bg_sel_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (cmd_i.load) begin
        samp_q <= sampling;
        cnt_q  <= (sampling && held_q < CntW'(Window)) ? held_q + CntW'(1) : held_q;
      end
      if (cmd_i.sort_start) begin
        step_q   <= '0;
        bg_sel_q <= 1'b0;
      end else if (cmd_i.sort_step && !sts_o.sort_done) begin
        step_q <= step_q + StepW'(1);
      end
      if (cmd_i.bg_read) begin
        bg_sel_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_o <= sts_o.emit;
        if (eof_q) begin
          pos_q <= '0;
          if (samp_q) begin
            phase_q <= '0;
            held_q  <= cnt_q;
            slot_q  <= (slot_q == SlotW'(Window - 1)) ? '0 : slot_q + SlotW'(1);
          end else begin
            phase_q <= phase_q + 16'd1;
          end
        end else begin
          pos_q <= (pos_q == PosW'(MaxPixels - 1)) ? '0 : pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      foreground_o       <= diff > fg_threshold_i;
      difference_o       <= diff;
      background_level_o <= bg_use;
      last_of_frame_o    <= eof_q;
    end
  end

endmodule

@@ rtl/median_background_subtractor.sv @@
// Top level: median background subtractor with APB register port.
// A sampling pixel passes the read, median sort and output states, any other pixel the
// read, background lookup and output states; a new pixel is taken only after the last
// result is handed off, and the odd-even median sorter and single-port ring memory
// of one wide word per pixel set the pace; a stalled result holds off the next pixel.
// Reset: control, counters and config regs reset; memories undefined until written.
module median_background_subtractor
  import mbs_pkg::*;
#(
  parameter int unsigned Window    = WindowDefault,
  parameter int unsigned MaxPixels = MaxPixelsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  gray_pixel_i,
  input  logic        end_of_frame_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        foreground_o,
  output logic [7:0]  difference_o,
  output logic [7:0]  background_level_o,
  output logic        last_of_frame_o
);

  logic [15:0] period_q;
  logic [7:0]  thresh_q;
  mbs_cmd_t    cmd;
  mbs_sts_t    sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
      thresh_q <= ThresholdReset;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegPeriod) begin
        period_q <= pwdata[15:0];
      end else begin
        thresh_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegThreshold) begin
      prdata = {24'd0, thresh_q};
    end else begin
      prdata = {16'd0, period_q};
    end
  end

  mbs_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  mbs_datapath #(
    .Window    (Window),
    .MaxPixels (MaxPixels)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .gray_pixel_i,
    .end_of_frame_i,
    .sample_period_i (period_q),
    .fg_threshold_i  (thresh_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o,
    .out_stall_i,
    .foreground_o,
    .difference_o,
    .background_level_o,
    .last_of_frame_o
  );

endmodule
